// ----- rtl/core/dtd_pkg.sv -----
// Shared types and constants of the DAB time de-interleaver.
package dtd_pkg;

  localparam int SoftW     = 16;
  localparam int CuW       = 10;
  localparam int BitsPerCu = 64;
  localparam int Rows      = 16;
  localparam int RowW      = 4;
  localparam int OutDepth  = 3;
  localparam int OutCntW   = 2;

  localparam logic [RowW-1:0] BitRev [Rows] = '{
    4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
    4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
  };

  typedef struct packed {
    logic [SoftW-1:0] soft_bit_out;
    logic             segment_last;
  } out_item_t;

endpackage

// ----- rtl/core/dtd_out_fifo.sv -----
// Three-entry output queue that decouples the store pipeline from the receiver.
module dtd_out_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  dtd_pkg::out_item_t      push_item_i,
  input  logic                    pop_ready_i,
  output logic                    pop_valid_o,
  output dtd_pkg::out_item_t      pop_item_o,
  output logic [dtd_pkg::OutCntW-1:0] count_o
);
  import dtd_pkg::*;

  out_item_t           entry_q [OutDepth];
  logic [OutCntW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [OutCntW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [OutCntW-1:0]  cnt_q, cnt_d;
  logic                pop;

  function automatic logic [OutCntW-1:0] next_ptr(input logic [OutCntW-1:0] ptr);
    next_ptr = (ptr == OutCntW'(OutDepth - 1)) ? '0 : ptr + OutCntW'(1);
  endfunction

  assign pop_valid_o = (cnt_q != '0);
  assign pop        = pop_valid_o && pop_ready_i;
  assign pop_item_o = entry_q[rd_ptr_q];
  assign count_o    = cnt_q;

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + OutCntW'(push_i) - OutCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- rtl/core/dab_time_deinterleaver.sv -----
// Top level of the DAB time de-interleaver with its delay store memory.
//
// Soft bits enter on the s_axis channel, one 16-bit signed value per item,
// and leave de-interleaved on the m_axis channel with tlast on the final
// soft bit of each segment. The segment size in capacity units is written
// on the cfg channel, which is always ready; write it only while idle.
// Each input item costs one read and one write of the delay store, done in
// the same cycle on its two ports, so one item is accepted every cycle
// while s_axis_tready is high. The memory read is registered at the
// accepting edge and moves into the output queue at the next edge, from
// which the result is offered on m_axis.
// A three-entry output queue absorbs receiver stalls; s_axis_tready drops
// only when the queue and the memory read stage would overfill.
// Reset clears the row, position and warmup counters and sets the segment
// size to one capacity unit. The store itself is not cleared: the first
// 16 segments after reset fill it and give no output items.
module dab_time_deinterleaver #(
  parameter int MaxCus = 864
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dtd_pkg::SoftW-1:0]   s_axis_tdata,   // [15:0] soft_bit
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [dtd_pkg::SoftW-1:0]   m_axis_tdata,   // [15:0] soft_bit_out
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dtd_pkg::CuW-1:0]     cfg_data_i
);
  import dtd_pkg::*;

  localparam int RowSize = MaxCus * BitsPerCu;
  localparam int PosW    = $clog2(RowSize);
  localparam int LenW    = $clog2(RowSize + 1);
  localparam int Depth   = Rows * RowSize;
  localparam int AddrW   = $clog2(Depth);
  localparam int WarmW   = 5;

  logic [SoftW-1:0]   store_q [Depth];
  logic [SoftW-1:0]   rd_data_q;

  logic [CuW-1:0]     cu_q;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [WarmW-1:0]   warm_q, warm_d;
  logic               s1_valid_q;
  logic               s1_last_q;

  logic [CuW-1:0]     cu_eff;
  logic [LenW-1:0]    seg_len;
  logic [RowW-1:0]    rd_row;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic               in_acc, last, emit;
  logic [OutCntW:0]   fill;
  logic [OutCntW-1:0] out_cnt;
  out_item_t          push_item, pop_item;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = s_axis_tvalid && s_axis_tready;

  assign fill          = (OutCntW+1)'(out_cnt) + (OutCntW+1)'(s1_valid_q);
  assign s_axis_tready = (fill <= (OutCntW+1)'(OutDepth - 1));

  always_comb begin
    if (cu_q == '0) begin
      cu_eff = CuW'(1);
    end else if (cu_q > CuW'(MaxCus)) begin
      cu_eff = CuW'(MaxCus);
    end else begin
      cu_eff = cu_q;
    end
    seg_len = LenW'(cu_eff) * LenW'(BitsPerCu);
    last    = ((LenW'(pos_q) + LenW'(1)) >= seg_len);
    emit    = warm_q[WarmW-1];
    rd_row  = row_q + BitRev[pos_q[RowW-1:0]];
    rd_addr = AddrW'(rd_row) * AddrW'(RowSize) + AddrW'(pos_q);
    wr_addr = AddrW'(row_q) * AddrW'(RowSize) + AddrW'(pos_q);

    pos_d  = pos_q;
    row_d  = row_q;
    warm_d = warm_q;
    if (in_acc) begin
      if (last) begin
        pos_d = '0;
        row_d = row_q + RowW'(1);
        if (!emit) begin
          warm_d = warm_q + WarmW'(1);
        end
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cu_q       <= CuW'(1);
      pos_q      <= '0;
      row_q      <= '0;
      warm_q     <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cu_q <= cfg_data_i;
      end
      pos_q      <= pos_d;
      row_q      <= row_d;
      warm_q     <= warm_d;
      s1_valid_q <= in_acc && emit;
      s1_last_q  <= last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      store_q[wr_addr] <= s_axis_tdata;
      rd_data_q        <= store_q[rd_addr];
    end
  end

  assign push_item.soft_bit_out = rd_data_q;
  assign push_item.segment_last = s1_last_q;

  dtd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_item_i (push_item),
    .pop_ready_i (m_axis_tready),
    .pop_valid_o (m_axis_tvalid),
    .pop_item_o  (pop_item),
    .count_o     (out_cnt)
  );

  assign m_axis_tdata = pop_item.soft_bit_out;
  assign m_axis_tlast = pop_item.segment_last;

endmodule

// ----- tb/sv/tb_dab_time_deinterleaver.sv -----
// Self-checking testbench of the DAB time de-interleaver with its own model of the delay rows.
module tb_dab_time_deinterleaver;
  import dtd_pkg::*;

  localparam int MaxCus   = 864;
  localparam int RowBits  = MaxCus * BitsPerCu;
  localparam int WarmCu   = 1;
  localparam int Warmup   = 16;
  localparam int SplitAt  = 200;
  localparam int Settle   = 8;
  localparam int MaxShown = 20;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [SoftW-1:0] s_axis_tdata;   // [15:0] soft_bit
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [SoftW-1:0] m_axis_tdata;   // [15:0] soft_bit_out
  logic             m_axis_tlast;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CuW-1:0]   cfg_data_i;

  dab_time_deinterleaver #(
    .MaxCus(MaxCus)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  logic [SoftW-1:0] delay_copy [int unsigned];
  int unsigned      row_fill [Rows];
  logic [RowW-1:0]  row_now;
  int unsigned      col_next;
  int unsigned      segs_seen;
  logic [CuW-1:0]   len_cu;
  out_item_t        pending_bits [$];
  int               err_count = 0;
  bit               src_idle_en;
  bit               sink_idle_en;
  int               sink_hold;

  function automatic void deinterleave_step(input logic [SoftW-1:0] sb);
    int unsigned     seg_len;
    int unsigned     col;
    int unsigned     rd_addr;
    logic [RowW-1:0] rd_row;
    logic [3:0]      low;
    out_item_t       res;
    bit              last;
    seg_len = (len_cu == 0) ? 1 : ((len_cu > MaxCus) ? MaxCus : len_cu);
    seg_len = seg_len * BitsPerCu;
    col = col_next;
    low = col[3:0];
    rd_row = row_now + {low[0], low[1], low[2], low[3]};
    rd_addr = int'(rd_row) * RowBits + col;
    res.soft_bit_out = delay_copy.exists(rd_addr) ? delay_copy[rd_addr] : '0;
    delay_copy[int'(row_now) * RowBits + col] = sb;
    if (col + 1 > row_fill[row_now]) begin
      row_fill[row_now] = col + 1;
    end
    last = (col + 1 >= seg_len);
    res.segment_last = last;
    if (segs_seen >= Warmup) begin
      pending_bits.push_back(res);
    end
    if (last) begin
      col_next = 0;
      row_now = row_now + 1'b1;
      if (segs_seen < Warmup) begin
        segs_seen++;
      end
    end else begin
      col_next = col + 1;
    end
  endfunction

  // Largest segment size whose columns are already present in every row.
  function automatic int unsigned covered_cu();
    int unsigned least;
    least = RowBits;
    foreach (row_fill[r]) begin
      if (row_fill[r] < least) begin
        least = row_fill[r];
      end
    end
    return least / BitsPerCu;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MaxShown) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic send_item(input logic [SoftW-1:0] sb);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= sb;
    do @(posedge clk_i); while (!s_axis_tready);
    deinterleave_step(sb);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_bits.size() != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic write_length(input logic [CuW-1:0] cu);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cu;
    do @(posedge clk_i); while (!cfg_ready_o);
    len_cu = cu;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // An oversized length runs row 0 long; shrinking it below the position ends the segment.
  task automatic test_cut_short();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    write_length('1);
    repeat (SplitAt) send_item(SoftW'($urandom));
    write_length(CuW'(WarmCu));
    send_item(SoftW'($urandom));
  endtask

  // The remaining rows get segments of the warmup size until output starts.
  task automatic test_warmup();
    int left;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    write_length(CuW'(WarmCu));
    left = (Warmup - int'(segs_seen)) * WarmCu * BitsPerCu;
    repeat (left) send_item(SoftW'($urandom));
  endtask

  task automatic test_field_extremes();
    logic [SoftW-1:0] fixed [10];
    fixed = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
              16'hFFFE, 16'h5555, 16'hAAAA, 16'h8001, 16'h7FFE};
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    foreach (fixed[k]) send_item(fixed[k]);
    for (int k = 0; k < 15; k++) begin
      send_item(SoftW'(1) << k);
    end
  endtask

  task automatic test_length_zero();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    write_length('0);
    repeat (100) send_item(SoftW'($urandom));
  endtask

  task automatic test_backpressure();
    write_length(CuW'(WarmCu));
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    sink_hold = 400;
    repeat (150) send_item(SoftW'($urandom));
    settle();
  endtask

  task automatic test_drain_pause();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    repeat (40) send_item(SoftW'($urandom));
    settle();
    repeat (40) send_item(SoftW'($urandom));
  endtask

  task automatic test_random_traffic();
    int sent;
    int blk;
    sent = 0;
    while (sent < 200) begin
      blk = $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) begin
        write_length(CuW'($urandom_range(0, covered_cu())));
      end
      if (sent >= 150) begin
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
      end else begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
      end
      repeat (blk) send_item(SoftW'($urandom));
      sent += blk;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(1, 5) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_bits.size() == 0) begin
        report_mismatch($sformatf("unexpected item soft_bit_out %h last %b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_bits.pop_front();
        if (m_axis_tdata !== want.soft_bit_out) begin
          report_mismatch($sformatf("soft_bit_out %h, wanted %h",
                                    m_axis_tdata, want.soft_bit_out));
        end
        if (m_axis_tlast !== want.segment_last) begin
          report_mismatch($sformatf("segment_last %b, wanted %b",
                                    m_axis_tlast, want.segment_last));
        end
      end
    end
  end

  initial begin
    repeat (4_000_000) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    sink_hold = 0;
    row_now = '0;
    col_next = 0;
    segs_seen = 0;
    len_cu = CuW'(1);
    foreach (row_fill[r]) row_fill[r] = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_cut_short();
    test_warmup();
    test_field_extremes();
    test_length_zero();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();
    settle();
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- dab_time_deinterleaver.f -----
rtl/core/dtd_pkg.sv
rtl/core/dtd_out_fifo.sv
rtl/core/dab_time_deinterleaver.sv
tb/sv/tb_dab_time_deinterleaver.sv
